// ===== rtl/bfr_pkg.sv =====
// Shared types and constants for the binary frame receiver.
package bfr_pkg;

    // Frame sync bytes.
    localparam logic [7:0] SYNC_FIRST = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // Maximum payload length after reset.
    localparam logic [15:0] MAX_LEN_RESET = 16'd100;

    // Event codes reported with each result word.
    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_PAYLOAD = 3'd1;
    localparam logic [2:0] EV_DONE = 3'd2;
    localparam logic [2:0] EV_SYNC_ERR = 3'd3;
    localparam logic [2:0] EV_LEN_ERR = 3'd4;
    localparam logic [2:0] EV_ABORT = 3'd5;

    // Parser phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } phase_t;

    // One received word.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       abort_frame;
    } in_word_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  message_class;
        logic [7:0]  message_id;
        logic [15:0] frame_length;
        logic [7:0]  check_first;
        logic [7:0]  check_second;
    } out_word_t;

endpackage

// ===== rtl/binary_frame_receiver_top.sv =====
// Binary frame receiver: byte-wise frame parser with a registered result and skid stage.
// Each result word is registered into out_data, or into the skid stage while the output word is stalled.
// Throughput: one input word per cycle while in_stall is low; each input word yields exactly one result word.
// The parser phase and held header fields update in the accept cycle, so back-to-back
// words need no bubbles; a two-entry output (result register plus skid) absorbs stalls.
// Reset clears the parser to idle, the held fields to zero and the length limit to 100.
module binary_frame_receiver_top
    import bfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data
);

    logic [15:0] max_len_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_class_reg, held_class_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  held_check_first_reg, held_check_first_next;

    out_word_t   out_data_reg, skid_data_reg, result;
    logic        out_valid_reg, skid_valid_reg;

    logic        accept;
    logic        out_take;
    logic [15:0] len_full;
    logic [2:0]  ev;
    logic [7:0]  pbyte;
    logic [15:0] pidx;
    logic [7:0]  ck1;
    logic [7:0]  ck2;

    // Handshake: stall input only while the skid stage is occupied.
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Length word assembled from the held low byte and the incoming high byte.
    assign len_full = {in_data.rx_byte, held_length_reg[7:0]};

    // Next parser state and the result for the incoming word.
    always_comb
    begin
        phase_next            = phase_reg;
        held_class_next       = held_class_reg;
        held_id_next          = held_id_reg;
        held_length_next      = held_length_reg;
        bytes_remaining_next  = bytes_remaining_reg;
        held_check_first_next = held_check_first_reg;
        ev    = EV_HEADER;
        pbyte = 8'd0;
        pidx  = 16'd0;
        ck1   = 8'd0;
        ck2   = 8'd0;

        if (in_data.abort_frame)
        begin
            ev         = EV_ABORT;
            phase_next = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (in_data.rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_CLASS;
                    end
                    else
                    begin
                        ev         = EV_SYNC_ERR;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CLASS:
                begin
                    held_class_next = in_data.rx_byte;
                    phase_next      = PH_ID;
                end
                PH_ID:
                begin
                    held_id_next = in_data.rx_byte;
                    phase_next   = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    held_length_next = {8'd0, in_data.rx_byte};
                    phase_next       = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    held_length_next = len_full;
                    if (len_full > max_len_reg)
                    begin
                        ev         = EV_LEN_ERR;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        bytes_remaining_next = len_full;
                        phase_next = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    ev    = EV_PAYLOAD;
                    pbyte = in_data.rx_byte;
                    pidx  = held_length_reg - bytes_remaining_reg;
                    bytes_remaining_next = bytes_remaining_reg - 16'd1;
                    if (bytes_remaining_reg == 16'd1)
                    begin
                        phase_next = PH_CK_A;
                    end
                end
                PH_CK_A:
                begin
                    held_check_first_next = in_data.rx_byte;
                    phase_next            = PH_CK_B;
                end
                PH_CK_B:
                begin
                    ev         = EV_DONE;
                    ck1        = held_check_first_reg;
                    ck2        = in_data.rx_byte;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // Idle, and any illegal code, waits for the first sync byte.
                    if (in_data.rx_byte == SYNC_FIRST)
                    begin
                        held_class_next  = 8'd0;
                        held_id_next     = 8'd0;
                        held_length_next = 16'd0;
                        phase_next       = PH_SYNC2;
                    end
                    else
                    begin
                        ev         = EV_SYNC_ERR;
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end

        result.event_res     = ev;
        result.payload_byte  = pbyte;
        result.payload_index = pidx;
        result.message_class = held_class_next;
        result.message_id    = held_id_next;
        result.frame_length  = held_length_next;
        result.check_first   = ck1;
        result.check_second  = ck2;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    // Parser state, updated once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_IDLE;
            held_class_reg       <= 8'd0;
            held_id_reg          <= 8'd0;
            held_length_reg      <= 16'd0;
            bytes_remaining_reg  <= 16'd0;
            held_check_first_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            held_class_reg       <= held_class_next;
            held_id_reg          <= held_id_next;
            held_length_reg      <= held_length_next;
            bytes_remaining_reg  <= bytes_remaining_next;
            held_check_first_reg <= held_check_first_next;
        end
    end

    // Output register and skid stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_reg <= result;
            end
            else
            begin
                skid_data_reg <= result;
            end
        end
    end

    // The skid stage is only ever filled behind a waiting result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // The skid stage fills only when the output word was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid stage filled while output was free");

    // In the payload phase there is always at least one byte left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (bytes_remaining_reg != 16'd0))
        else $error("payload phase with no bytes remaining");

    // A reported payload index always lies inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.event_res == EV_PAYLOAD)
            |-> (out_data_reg.payload_index < out_data_reg.frame_length))
        else $error("payload index beyond frame length");

endmodule

// ===== dv/frame_result_checker.sv =====
// Result checker for the binary frame receiver: predicts each result word and compares it.
module frame_result_checker
    import bfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_data,
    output int          pending_results,
    output int          mismatch_count
);

    // Shadow copy of the parser state and the length limit.
    phase_t      parse_phase;
    logic [7:0]  held_class;
    logic [7:0]  held_id;
    logic [15:0] held_length;
    logic [15:0] bytes_left;
    logic [7:0]  held_check_first;
    logic [15:0] length_limit;

    // Result words predicted but not yet seen on the output.
    out_word_t   expected_words[$];
    int          result_number;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("result %0d: %s", result_number, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Advance the shadow parser by one accepted word and build the result it gives.
    task automatic parse_word(input in_word_t w, output out_word_t r);
        r = '0;
        r.event_res = EV_HEADER;
        if (w.abort_frame) begin
            r.event_res = EV_ABORT;
            parse_phase = PH_IDLE;
        end else begin
            case (parse_phase)
                PH_SYNC2:
                begin
                    if (w.rx_byte == SYNC_SECOND) begin
                        parse_phase = PH_CLASS;
                    end else begin
                        r.event_res = EV_SYNC_ERR;
                        parse_phase = PH_IDLE;
                    end
                end
                PH_CLASS:
                begin
                    held_class = w.rx_byte;
                    parse_phase = PH_ID;
                end
                PH_ID:
                begin
                    held_id = w.rx_byte;
                    parse_phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    held_length = {8'h00, w.rx_byte};
                    parse_phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    held_length = {w.rx_byte, held_length[7:0]};
                    if (held_length > length_limit) begin
                        r.event_res = EV_LEN_ERR;
                        parse_phase = PH_IDLE;
                    end else begin
                        bytes_left = held_length;
                        parse_phase = (held_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    r.event_res = EV_PAYLOAD;
                    r.payload_byte = w.rx_byte;
                    r.payload_index = held_length - bytes_left;
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        parse_phase = PH_CK_A;
                end
                PH_CK_A:
                begin
                    held_check_first = w.rx_byte;
                    parse_phase = PH_CK_B;
                end
                PH_CK_B:
                begin
                    r.event_res = EV_DONE;
                    r.check_first = held_check_first;
                    r.check_second = w.rx_byte;
                    parse_phase = PH_IDLE;
                end
                default:
                begin
                    // A first sync byte starts a new frame and clears the held header.
                    if (w.rx_byte == SYNC_FIRST) begin
                        held_class = 8'h00;
                        held_id = 8'h00;
                        held_length = 16'h0000;
                        parse_phase = PH_SYNC2;
                    end else begin
                        r.event_res = EV_SYNC_ERR;
                        parse_phase = PH_IDLE;
                    end
                end
            endcase
        end
        r.message_class = held_class;
        r.message_id = held_id;
        r.frame_length = held_length;
    endtask

    // Compare outgoing words first, then take the register write and the incoming word.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_word_t want;
        out_word_t predicted;
        if (!rst_n) begin
            parse_phase = PH_IDLE;
            held_class = 8'h00;
            held_id = 8'h00;
            held_length = 16'h0000;
            bytes_left = 16'h0000;
            held_check_first = 8'h00;
            length_limit = MAX_LEN_RESET;
            expected_words.delete();
            result_number = 0;
            mismatch_count = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with none expected");
                end else begin
                    want = expected_words.pop_front();
                    check_field("event", 16'(out_data.event_res), 16'(want.event_res));
                    check_field("payload byte", 16'(out_data.payload_byte),
                                16'(want.payload_byte));
                    check_field("payload index", out_data.payload_index, want.payload_index);
                    check_field("class", 16'(out_data.message_class),
                                16'(want.message_class));
                    check_field("id", 16'(out_data.message_id), 16'(want.message_id));
                    check_field("length", out_data.frame_length, want.frame_length);
                    check_field("first checksum", 16'(out_data.check_first),
                                16'(want.check_first));
                    check_field("second checksum", 16'(out_data.check_second),
                                16'(want.check_second));
                end
                result_number++;
            end
            if (cfg_write_en)
                length_limit = cfg_write_data;
            if (in_valid && !in_stall) begin
                parse_word(in_data, predicted);
                expected_words.push_back(predicted);
            end
        end
        pending_results = expected_words.size();
    end

endmodule

// ===== dv/tb_binary_frame_receiver_top.sv =====
// Testbench top for the binary frame receiver: stimulus, idling, watchdog and verdict.
module tb_binary_frame_receiver_top;
    import bfr_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int BODY_CAP = 104;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic [15:0] cfg_write_data = 16'h0000;
    logic        in_valid = 1'b0;
    in_word_t    in_data = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    out_word_t   out_data;

    int          pending_results;
    int          mismatch_count;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    logic [15:0] limit_setting = MAX_LEN_RESET;
    bit          idling_on = 1'b1;
    bit          hold_request = 1'b0;

    binary_frame_receiver_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    frame_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // End the run if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else begin
                out_stall <= idling_on && ($urandom_range(99) < 24);
            end
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_word(input logic [7:0] b, input logic abort_now);
        while (idling_on && $urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{rx_byte: b, abort_frame: abort_now};
        do begin
            @(posedge clk);
        end while (in_stall);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted result word has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (pending_results != 0);
        @(posedge clk);
    endtask

    task automatic write_length_limit(input logic [15:0] value);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        limit_setting = value;
    endtask

    // One random stretch of traffic: mostly frames, some noise, broken syncs and aborts.
    task automatic send_frame();
        logic [7:0]  frame_bytes[$];
        logic [7:0]  bad_sync;
        logic [15:0] len;
        int          kind;
        int          small_max;
        int          body;
        int          cut;
        kind = $urandom_range(99);
        cut = -1;
        if (kind < 8) begin
            send_word(8'($urandom_range(255)), 1'b0);
        end else if (kind < 12) begin
            send_word(8'($urandom_range(255)), 1'b1);
        end else if (kind < 18) begin
            // Second sync byte wrong.
            bad_sync = 8'($urandom_range(255));
            if (bad_sync == SYNC_SECOND)
                bad_sync = SYNC_FIRST;
            send_word(SYNC_FIRST, 1'b0);
            send_word(bad_sync, 1'b0);
        end else begin
            small_max = (limit_setting < 12) ? limit_setting : 12;
            if (kind < 28)
                len = 16'($urandom_range(65535));
            else if (kind < 33)
                len = limit_setting;
            else if (kind < 37 && limit_setting != 16'hFFFF)
                len = limit_setting + 16'd1;
            else
                len = 16'($urandom_range(small_max));
            frame_bytes = '{SYNC_FIRST, SYNC_SECOND, 8'($urandom_range(255)),
                            8'($urandom_range(255)), len[7:0], len[15:8]};
            // Payload and checksum bytes only follow an accepted length.
            body = (len > limit_setting) ? 0 : int'(len) + 2;
            if (body > BODY_CAP) begin
                body = BODY_CAP;
                cut = 6 + $urandom_range(BODY_CAP);
            end
            repeat (body) frame_bytes.push_back(8'($urandom_range(255)));
            if (cut < 0 && $urandom_range(99) < 12)
                cut = $urandom_range(1, frame_bytes.size());
            for (int i = 0; i <= frame_bytes.size(); i++) begin
                if (i == cut) begin
                    send_word(8'($urandom_range(255)), 1'b1);
                    break;
                end
                if (i < frame_bytes.size())
                    send_word(frame_bytes[i], 1'b0);
            end
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target)
            send_frame();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Abort while idle, a stray byte, and a repeated first sync byte that must not
        // count as a new frame start (the following second sync byte is then an error).
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(SYNC_FIRST, 1'b0);
        send_word(SYNC_FIRST, 1'b0);
        send_word(SYNC_SECOND, 1'b0);
        // Zero-length frame with extreme header and checksum values.
        send_word(SYNC_FIRST, 1'b0);
        send_word(SYNC_SECOND, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        // Length one above the reset limit.
        send_word(SYNC_FIRST, 1'b0);
        send_word(SYNC_SECOND, 1'b0);
        send_word(8'h7E, 1'b0);
        send_word(8'h81, 1'b0);
        send_word(8'h65, 1'b0);
        send_word(8'h00, 1'b0);
        // One payload byte, then an abort before the checksum.
        send_word(SYNC_FIRST, 1'b0);
        send_word(SYNC_SECOND, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h02, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'hA5, 1'b1);

        // Reset limit, with one long receiver hold-off while words keep coming.
        hold_request = 1'b1;
        run_random(230);
        write_length_limit(16'h0000);
        run_random(150);
        write_length_limit(16'hFFFF);
        idling_on = 1'b0;
        run_random(150);
        idling_on = 1'b1;
        run_random(120);
        write_length_limit(16'd8);
        run_random(220);
        write_length_limit(16'($urandom_range(65535)));
        run_random(200);
        write_length_limit(16'($urandom_range(40)));
        run_random(200);

        drain_results();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
